FILE: rtl/tcc_pkg.sv
// tcc_pkg: shared types and constants for the text console cursor engine
// holds command codes, character codes and the request/response word types
`timescale 1ns / 1ps

package tcc_pkg;

  // command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // control characters and printable range
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

  // blank cell: white on black space
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  localparam int TAB_STOP = 8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [3:0]  bg_color;
    logic [3:0]  fg_color;
    logic [10:0] read_addr;
  } req_word_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
    logic        scrolled;
  } rsp_word_t;

endpackage

FILE: rtl/tcc_stream_if.sv
// tcc_stream_if: valid/ready channel carrying one word of a given type
// depends on nothing; payload type is supplied by the user (see tcc_pkg)
`timescale 1ns / 1ps

interface tcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/text_console_cursor_engine_top.sv
// text_console_cursor_engine_top: cell buffer, cursor and sequencer of the console
// depends on tcc_pkg (types, codes) and tcc_stream_if (channels)
// Flow: an in-range read goes via S_READ to S_RESULT; a plain put, an out-of-range read
//   or an unused cmd goes to S_RESULT; clear and scroll sweep one cell per cycle.
// Throughput: one word at a time; the cell memory (one write, one read port) and its sweep
//   counter set the time of clear and scroll, the rest is bounded by the sequencer.
// Reset: cursor homes, then a clearing pass blanks the memory, with req.ready low
//   throughout the pass.
`timescale 1ns / 1ps

module text_console_cursor_engine_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk,
  input  logic rst,
  tcc_stream_if.sink   req,
  tcc_stream_if.source rsp
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW      = COL_W + 4;
  localparam int POS_W   = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int MOVE_N  = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_SCROLL, S_BLANK, S_RESULT
  } state_t;

  state_t state;
  logic              clr_reply;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] cp_dst;
  logic              cp_valid;
  logic [15:0]       res_cell;
  logic              res_scrolled;

  // cell memory
  logic [15:0]       cells [CELLS];
  logic [15:0]       rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;

  logic              accept;
  tcc_pkg::req_word_t rq;
  logic [POS_W-1:0]  rd_addr_w;

  assign rq        = req.data;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rd_addr_w = POS_W'(rq.read_addr);

  // cursor update for a put
  logic [CW-1:0]     col_w;
  logic [CW-1:0]     col_new;
  logic              row_inc;
  logic              printable;
  logic              put_scroll;
  logic [ADDR_W-1:0] cur_idx;
  logic [POS_W-1:0]  pos_wide;

  always_comb begin
    col_w     = CW'(col);
    col_new   = col_w;
    row_inc   = 1'b0;
    printable = (rq.char_code >= tcc_pkg::CH_PRINT_LO) &&
                (rq.char_code <= tcc_pkg::CH_PRINT_HI);
    priority if (rq.char_code == tcc_pkg::CH_BS) begin
      if (col_w != '0) col_new = col_w - CW'(1);
    end else if (rq.char_code == tcc_pkg::CH_TAB) begin
      col_new = (col_w + CW'(tcc_pkg::TAB_STOP)) & ~CW'(tcc_pkg::TAB_STOP - 1);
    end else if (rq.char_code == tcc_pkg::CH_CR) begin
      col_new = '0;
    end else if (rq.char_code == tcc_pkg::CH_LF) begin
      col_new = '0;
      row_inc = 1'b1;
    end else if (printable) begin
      col_new = col_w + CW'(1);
    end else begin
      col_new = col_w;
    end
    // wrap past the last column
    if (col_new >= CW'(COLUMNS)) begin
      col_new = '0;
      row_inc = 1'b1;
    end
    put_scroll = row_inc && (row == ROW_W'(ROWS - 1));
  end

  assign cur_idx  = row_base + ADDR_W'(col);
  assign pos_wide = POS_W'(cur_idx);

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = tcc_pkg::BLANK_CELL;
    raddr = ptr + ADDR_W'(COLUMNS);
    unique case (state)
      S_CLEAR, S_BLANK: begin
        we = 1'b1;
      end
      S_IDLE: begin
        raddr = rd_addr_w[ADDR_W-1:0];
        if (accept && rq.cmd == tcc_pkg::CMD_PUT && printable) begin
          we    = 1'b1;
          waddr = cur_idx;
          wdata = {rq.bg_color, rq.fg_color, rq.char_code};
        end
      end
      S_SCROLL: begin
        we    = cp_valid;
        waddr = cp_dst;
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) cells[waddr] <= wdata;
    rdata <= cells[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_reply <= 1'b0;
      col       <= '0;
      row       <= '0;
      row_base  <= '0;
      ptr       <= '0;
      cp_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_RESULT) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + ADDR_W'(1);
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr          <= '0;
            res_cell     <= '0;
            res_scrolled <= 1'b0;
            state        <= clr_reply ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_cell     <= '0;
            res_scrolled <= 1'b0;
            priority if (rq.cmd == tcc_pkg::CMD_PUT) begin
              col <= col_new[COL_W-1:0];
              if (put_scroll) begin
                res_scrolled <= 1'b1;
                ptr          <= '0;
                cp_valid     <= 1'b0;
                state        <= S_SCROLL;
              end else begin
                if (row_inc) begin
                  row      <= row + ROW_W'(1);
                  row_base <= row_base + ADDR_W'(COLUMNS);
                end
                state <= S_RESULT;
              end
            end else if (rq.cmd == tcc_pkg::CMD_CLEAR) begin
              col       <= '0;
              row       <= '0;
              row_base  <= '0;
              ptr       <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else if (rq.cmd == tcc_pkg::CMD_READ &&
                         32'(rq.read_addr) < 32'(CELLS)) begin
              state <= S_READ;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_READ: begin
          res_cell <= rdata;
          state    <= S_RESULT;
        end
        S_SCROLL: begin
          // read one row down, write it back in the following cycle
          cp_dst   <= ptr;
          cp_valid <= (ptr < ADDR_W'(MOVE_N));
          if (ptr == ADDR_W'(MOVE_N)) begin
            state <= S_BLANK;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_BLANK: begin
          ptr <= ptr + ADDR_W'(1);
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr   <= '0;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.data.cursor_pos <= pos_wide[10:0];
            rsp.data.cell_data  <= res_cell;
            rsp.data.scrolled   <= res_scrolled;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // cursor stays on screen
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < 32'(COLUMNS)) && (32'(row) < 32'(ROWS)))
    else $error("cursor left the screen");

  // row base tracks the row
  a_row_base: assert property (@(posedge clk) disable iff (rst)
    32'(row_base) == 32'(row) * 32'(COLUMNS))
    else $error("row base out of step with row");

  // a scroll only follows a put
  a_scroll_from_put: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) && !$past(state == S_SCROLL) |->
      $past(accept && rq.cmd == tcc_pkg::CMD_PUT))
    else $error("scroll without a put");

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word did not start work");

  // the sweep copy never runs into the blank row
  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) && cp_valid |-> cp_dst < ADDR_W'(MOVE_N))
    else $error("scroll copy past the moved region");

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for text_console_cursor_engine_top (80 x 25 screen)
// depends on tcc_pkg (codes, word types) and tcc_stream_if (request/response channels)
// a directed table runs first, then random console traffic is checked against a cell predictor
`timescale 1ns / 1ps

module testbench;

  localparam int N_COLS      = 80;
  localparam int N_ROWS      = 25;
  localparam int CELLS       = N_COLS * N_ROWS;
  localparam int RAND_WORDS  = 850;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int N_PLAN      = 24;

  // the block treats command code 3 as a no-op
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    tcc_pkg::req_word_t word;
    logic               fixed;
    tcc_pkg::rsp_word_t rsp;
  } plan_row_t;

  logic clk;
  logic rst;

  tcc_stream_if #(.payload_t(tcc_pkg::req_word_t)) req_if ();
  tcc_stream_if #(.payload_t(tcc_pkg::rsp_word_t)) rsp_if ();

  text_console_cursor_engine_top #(
    .COLUMNS(N_COLS),
    .ROWS   (N_ROWS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // predicted screen contents and cursor
  logic [15:0] screen [CELLS];
  int          cur_col;
  int          cur_row;
  logic [10:0] last_pos;

  tcc_pkg::rsp_word_t pending [$];
  logic               fixed_on;
  tcc_pkg::rsp_word_t fixed_word;

  bit          steady;
  bit          hold_sink;
  int          mismatches;
  int          n_scrolls;
  int          n_reads;
  int          n_clears;
  int          n_words;
  int          quiet;

  // directed table: typed-in result where it is obvious, predictor otherwise
  plan_row_t dir_plan [N_PLAN] = '{
    '{'{tcc_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0},    1'b1, '{11'd0,  16'h0F20, 1'b0}},
    '{'{tcc_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd1999}, 1'b1, '{11'd0,  16'h0F20, 1'b0}},
    '{'{tcc_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd2000}, 1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_READ, 8'hFF, 4'hF, 4'hF, 11'h7FF},  1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{'{CMD_NONE,          8'h41, 4'hF, 4'hF, 11'd5},    1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT,  8'h41, 4'hF, 4'h0, 11'd0},    1'b1, '{11'd1,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 11'd0},    1'b1, '{11'd1,  16'hF041, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_BS, 4'h0, 4'h0, 11'd0}, 1'b1,
      '{11'd0,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_BS, 4'h0, 4'h0, 11'd0}, 1'b1,
      '{11'd0,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_TAB, 4'h0, 4'h0, 11'd0}, 1'b1,
      '{11'd8,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_CR, 4'h0, 4'h0, 11'd0}, 1'b1,
      '{11'd0,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_LF, 4'h0, 4'h0, 11'd0}, 1'b1,
      '{11'd80, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_PRINT_LO, 4'h0, 4'h0, 11'd0}, 1'b1,
      '{11'd81, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_PRINT_HI, 4'hF, 4'hF, 11'd0}, 1'b1,
      '{11'd82, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_READ,  8'h00, 4'h0, 4'h0, 11'd81},  1'b1, '{11'd82, 16'hFF7F, 1'b0}},
    '{'{tcc_pkg::CMD_PUT,   8'h1F, 4'h3, 4'h3, 11'd0},   1'b1, '{11'd82, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT,   8'h80, 4'h3, 4'h3, 11'd0},   1'b1, '{11'd82, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT,   8'hFF, 4'h3, 4'h3, 11'd0},   1'b1, '{11'd82, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_PUT,   8'h00, 4'h3, 4'h3, 11'd0},   1'b1, '{11'd82, 16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0},   1'b1, '{11'd0,  16'h0000, 1'b0}},
    '{'{tcc_pkg::CMD_READ,  8'h00, 4'h0, 4'h0, 11'd81},  1'b1, '{11'd0,  16'h0F20, 1'b0}},
    '{'{tcc_pkg::CMD_PUT,   8'h7E, 4'h5, 4'hA, 11'd0},   1'b0, '0},
    '{'{tcc_pkg::CMD_PUT, tcc_pkg::CH_TAB, 4'h0, 4'h0, 11'd0}, 1'b0, '0},
    '{'{tcc_pkg::CMD_READ,  8'h00, 4'h0, 4'h0, 11'd0},   1'b0, '0}
  };

  // cursor and cell predictor: applies one command word, returns its result
  function automatic tcc_pkg::rsp_word_t console_step(input tcc_pkg::req_word_t w);
    tcc_pkg::rsp_word_t r;
    r = '0;
    case (w.cmd)
      tcc_pkg::CMD_PUT: begin
        case (w.char_code)
          tcc_pkg::CH_BS: begin
            if (cur_col != 0) cur_col--;
          end
          tcc_pkg::CH_TAB: cur_col = (cur_col + tcc_pkg::TAB_STOP) & ~(tcc_pkg::TAB_STOP - 1);
          tcc_pkg::CH_CR: cur_col = 0;
          tcc_pkg::CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            if (w.char_code >= tcc_pkg::CH_PRINT_LO &&
                w.char_code <= tcc_pkg::CH_PRINT_HI) begin
              screen[cur_row * N_COLS + cur_col] = {w.bg_color, w.fg_color, w.char_code};
              cur_col++;
            end
          end
        endcase
        // wrap past the last column
        if (cur_col >= N_COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row past the last row
        if (cur_row >= N_ROWS) begin
          for (int i = 0; i < CELLS - N_COLS; i++) screen[i] = screen[i + N_COLS];
          for (int i = CELLS - N_COLS; i < CELLS; i++) screen[i] = tcc_pkg::BLANK_CELL;
          cur_row = N_ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      tcc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = tcc_pkg::BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      tcc_pkg::CMD_READ: begin
        if (w.read_addr < CELLS) r.cell_data = screen[w.read_addr];
      end
      default: ;
    endcase
    r.cursor_pos = 11'(cur_row * N_COLS + cur_col);
    return r;
  endfunction

  // offer one word, with an occasional gap before it
  task automatic offer(input tcc_pkg::req_word_t w, input logic fixed,
                       input tcc_pkg::rsp_word_t fixed_rsp);
    if (!steady && $urandom_range(99) < 8) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    fixed_on     <= fixed;
    fixed_word   <= fixed_rsp;
    if (w.cmd == tcc_pkg::CMD_READ) n_reads++;
    if (w.cmd == tcc_pkg::CMD_CLEAR) n_clears++;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // prediction on request accept, field check on response accept
  always @(posedge clk) begin
    tcc_pkg::rsp_word_t want;
    tcc_pkg::rsp_word_t got;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = tcc_pkg::BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
      last_pos = '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        want = console_step(req_if.data);
        if (fixed_on) want = fixed_word;
        pending.push_back(want);
        last_pos = want.cursor_pos;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (got.scrolled) n_scrolls++;
        if (pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: pos %0d cell %h scroll %0d",
                     got.cursor_pos, got.cell_data, got.scrolled);
        end else begin
          want = pending.pop_front();
          if (got.cursor_pos !== want.cursor_pos || got.cell_data !== want.cell_data ||
              got.scrolled !== want.scrolled) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pos exp %0d got %0d, cell exp %h got %h, scroll exp %0d got %0d",
                       want.cursor_pos, got.cursor_pos, want.cell_data, got.cell_data,
                       want.scrolled, got.scrolled);
          end
        end
      end
    end
  end

  // watchdog on cycles with no traffic on either channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet = 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet++;
    end
  end

  // stimulus
  initial begin
    tcc_pkg::req_word_t w;
    int        pick;
    bit        held;
    bit        paused;
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    fixed_on     <= 1'b0;
    fixed_word   <= '0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_plan[i]) offer(dir_plan[i].word, dir_plan[i].fixed, dir_plan[i].rsp);

    // random console traffic: mostly text lines with control bytes mixed in
    while (n_words < RAND_WORDS) begin
      steady = (n_words >= 100 && n_words < 300);
      if (n_words >= 400 && !held) begin
        hold_sink = 1'b1;
        held = 1'b1;
      end
      // drain everything once mid-run
      if (n_words >= 600 && !paused) begin
        paused = 1'b1;
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending.size() != 0);
      end
      w.cmd        = tcc_pkg::CMD_PUT;
      w.char_code  = 8'($urandom_range(32, 127));
      w.bg_color   = 4'($urandom_range(15));
      w.fg_color   = 4'($urandom_range(15));
      w.read_addr  = 11'($urandom_range(2047));
      pick = $urandom_range(99);
      if (pick < 55) ;
      else if (pick < 65) w.char_code = tcc_pkg::CH_LF;
      else if (pick < 70) w.char_code = tcc_pkg::CH_TAB;
      else if (pick < 75) w.char_code = tcc_pkg::CH_BS;
      else if (pick < 78) w.char_code = tcc_pkg::CH_CR;
      else if (pick < 80) w.char_code = 8'($urandom_range(255));
      else if (pick < 82) w.cmd = tcc_pkg::CMD_CLEAR;
      else if (pick < 98) begin
        w.cmd = tcc_pkg::CMD_READ;
        case ($urandom_range(2))
          0: w.read_addr = (last_pos == 0) ? 11'd0 : last_pos - 11'd1;
          1: w.read_addr = 11'($urandom_range(CELLS - N_COLS, CELLS - 1));
          default: ;
        endcase
      end else begin
        w.cmd = CMD_NONE;
      end
      offer(w, 1'b0, '0);
      // ignored bytes and no-op commands do not count toward the run length
      if (!(w.cmd == CMD_NONE || (w.cmd == tcc_pkg::CMD_PUT &&
            w.char_code != tcc_pkg::CH_BS && w.char_code != tcc_pkg::CH_TAB &&
            w.char_code != tcc_pkg::CH_CR && w.char_code != tcc_pkg::CH_LF &&
            (w.char_code < tcc_pkg::CH_PRINT_LO || w.char_code > tcc_pkg::CH_PRINT_HI))))
        n_words++;
    end
    steady = 1'b0;
    req_if.valid <= 1'b0;

    // wait for the last results, then idle before the summary
    do @(posedge clk); while (pending.size() != 0);
    repeat (8) @(posedge clk);

    $display("ran %0d directed and %0d counted random words", N_PLAN, n_words);
    $display("saw %0d reads, %0d clears, %0d scrolls", n_reads, n_clears, n_scrolls);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tcc_pkg.sv
rtl/tcc_stream_if.sv
rtl/text_console_cursor_engine_top.sv
dv/testbench.sv
